>>> src/genotype_ibs_counter_macros.svh
// ----------------------------------------------------------------------------
// Genotype IBS counter assertion macros
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GENOTYPE_IBS_COUNTER_MACROS_SVH
`define GENOTYPE_IBS_COUNTER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define GIC_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define GIC_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/gic_pkg.sv
// ----------------------------------------------------------------------------
// Genotype IBS counter package
// Widths, codes, the classified-beat type and shared arithmetic helpers.
// ----------------------------------------------------------------------------
package gic_pkg;

  // Running counter width; results carry the low OUT_BITS of each counter.
  localparam int unsigned COUNT_BITS  = 32;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned GENO_NUM    = WORD_BITS / 2;
  localparam int unsigned OUT_BITS    = 32;
  localparam int unsigned CLASS_BITS  = $clog2(GENO_NUM + 1);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Two-bit code 10 in every genotype slot marks a missing call.
  localparam logic [WORD_BITS-1:0] MISS_CODE = 64'hAAAA_AAAA_AAAA_AAAA;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [GENO_NUM-1:0]   geno_mask_t;
  typedef logic [CLASS_BITS-1:0] cnt_t;
  typedef logic [COUNT_BITS-1:0] total_t;
  typedef logic [OUT_BITS-1:0]   out_t;

  // One classified beat: per-class position counts of a word pair.
  typedef struct packed {
    logic last;
    cnt_t n0;
    cnt_t n1;
    cnt_t n2;
  } cls_t;

  // Population count of one genotype mask as a balanced adder tree.
  function automatic cnt_t popcount(geno_mask_t m);
    logic [1:0] l1 [16];
    logic [2:0] l2 [8];
    logic [3:0] l3 [4];
    logic [4:0] l4 [2];
    for (int i = 0; i < 16; i++) begin
      l1[i] = {1'b0, m[2*i]} + {1'b0, m[2*i+1]};
    end
    for (int i = 0; i < 8; i++) begin
      l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
    end
    for (int i = 0; i < 4; i++) begin
      l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
    end
    for (int i = 0; i < 2; i++) begin
      l4[i] = {1'b0, l3[2*i]} + {1'b0, l3[2*i+1]};
    end
    return {1'b0, l4[0]} + {1'b0, l4[1]};
  endfunction

  // Add a beat count to a running total, sticking at the all-ones value.
  function automatic total_t sat_add(total_t t, cnt_t n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, t} + (COUNT_BITS + 1)'(n);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

endpackage

>>> src/gic_in_if.sv
// ----------------------------------------------------------------------------
// Genotype word pair channel
// Valid/ready channel carrying two packed genotype words and a last flag.
// ----------------------------------------------------------------------------
interface gic_in_if
  import gic_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t x_word;
  word_t y_word;
  logic  last_word;

  modport source (output valid, output x_word, output y_word, output last_word,
                  input ready);
  modport sink   (input valid, input x_word, input y_word, input last_word,
                  output ready);
endinterface

>>> src/gic_out_if.sv
// ----------------------------------------------------------------------------
// IBS count result channel
// Valid/ready channel carrying the three IBS totals of one sample pair.
// ----------------------------------------------------------------------------
interface gic_out_if
  import gic_pkg::*;
;
  logic valid;
  logic ready;
  out_t ibs0_count;
  out_t ibs1_count;
  out_t ibs2_count;

  modport source (output valid, output ibs0_count, output ibs1_count,
                  output ibs2_count, input ready);
  modport sink   (input valid, input ibs0_count, input ibs1_count,
                  input ibs2_count, output ready);
endinterface

>>> src/gic_front.sv
// ----------------------------------------------------------------------------
// IBS front end
// Accepts word pairs, classifies every genotype slot and registers the
// per-class counts as one compact beat.
// ----------------------------------------------------------------------------
`include "genotype_ibs_counter_macros.svh"

module gic_front
  import gic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gic_in_if.sink    in_i,
  output cls_t      cls_o,
  output logic      cls_valid_o,
  input  logic      cls_ready_i
);

  logic       valid_q, valid_d;
  cls_t       cls_q;
  geno_mask_t zero_m, one_m, two_m;
  logic       accept;

  // Per-slot classification; a slot missing in either sample counts nowhere.
  always_comb begin
    logic xp, yp, same_lo, same_hi;
    for (int i = 0; i < GENO_NUM; i++) begin
      xp      = |(in_i.x_word[2*i +: 2] ^ MISS_CODE[2*i +: 2]);
      yp      = |(in_i.y_word[2*i +: 2] ^ MISS_CODE[2*i +: 2]);
      same_lo = ~(in_i.x_word[2*i] ^ in_i.y_word[2*i]);
      same_hi = ~(in_i.x_word[2*i+1] ^ in_i.y_word[2*i+1]);
      two_m[i]  = same_lo & same_hi & xp & yp;
      one_m[i]  = (same_lo ^ same_hi) & xp & yp;
      zero_m[i] = ~(same_lo | same_hi) & xp & yp;
    end
  end

  // The stage takes a new beat when empty or when its beat leaves.
  assign in_i.ready = !valid_q || cls_ready_i;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (cls_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cls_q.last <= in_i.last_word;
      cls_q.n0   <= popcount(zero_m);
      cls_q.n1   <= popcount(one_m);
      cls_q.n2   <= popcount(two_m);
    end
  end

  assign cls_o       = cls_q;
  assign cls_valid_o = valid_q;

  // A word has 32 slots, so the three classes can never cover more.
  `GIC_ASSERT_ALWAYS(a_front_slot_sum,
    !valid_q || (7'(cls_q.n0) + 7'(cls_q.n1) + 7'(cls_q.n2) <= 7'(GENO_NUM)),
    "front: class counts exceed the slots of one word")

endmodule

>>> src/gic_queue.sv
// ----------------------------------------------------------------------------
// IBS classified-beat queue
// Short FIFO between the front end and the accumulator so each side can
// stall on its own.
// ----------------------------------------------------------------------------
`include "genotype_ibs_counter_macros.svh"

module gic_queue
  import gic_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cls_t push_data_i,
  input  logic push_valid_i,
  output logic push_ready_o,
  output cls_t pop_data_o,
  output logic pop_valid_o,
  input  logic pop_ready_i
);

  cls_t                 mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [QCNT_BITS-1:0] count_q, count_d;
  logic                 push, pop;

  assign push_ready_o = (count_q != QCNT_BITS'(QUEUE_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push) begin
      wptr_d = (wptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop) begin
      rptr_d = (rptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

  // The fill level moves by exactly the beats that entered and left.
  `GIC_ASSERT_NEXT(a_queue_fill,
    1'b1,
    count_q == $past(count_q) + QCNT_BITS'($past(push)) - QCNT_BITS'($past(pop)),
    "queue: fill level does not track pushes and pops")

endmodule

>>> src/gic_back.sv
// ----------------------------------------------------------------------------
// IBS accumulator
// Adds classified beats into three saturating totals and, on a last beat,
// loads the result register and clears the totals.
// ----------------------------------------------------------------------------
`include "genotype_ibs_counter_macros.svh"

module gic_back
  import gic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cls_t      head_i,
  input  logic      head_valid_i,
  output logic      head_ready_o,
  gic_out_if.source out_o
);

  total_t tot0_q, tot0_d, tot1_q, tot1_d, tot2_q, tot2_d;
  total_t sum0, sum1, sum2;
  logic   out_valid_q, out_valid_d;
  out_t   res0_q, res1_q, res2_q;
  logic   pop, emit;

  // Non-last beats always drain; a last beat needs the result slot free.
  assign head_ready_o = !head_i.last || !out_valid_q || out_o.ready;
  assign pop          = head_valid_i && head_ready_o;
  assign emit         = pop && head_i.last;

  assign sum0 = sat_add(tot0_q, head_i.n0);
  assign sum1 = sat_add(tot1_q, head_i.n1);
  assign sum2 = sat_add(tot2_q, head_i.n2);

  // Totals accumulate, and restart from zero after a last beat.
  always_comb begin
    tot0_d = tot0_q;
    tot1_d = tot1_q;
    tot2_d = tot2_q;
    if (emit) begin
      tot0_d = '0;
      tot1_d = '0;
      tot2_d = '0;
    end else if (pop) begin
      tot0_d = sum0;
      tot1_d = sum1;
      tot2_d = sum2;
    end
  end

  // Result register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tot0_q      <= '0;
      tot1_q      <= '0;
      tot2_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tot0_q      <= tot0_d;
      tot1_q      <= tot1_d;
      tot2_q      <= tot2_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res0_q <= OUT_BITS'(sum0);
      res1_q <= OUT_BITS'(sum1);
      res2_q <= OUT_BITS'(sum2);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ibs0_count = res0_q;
  assign out_o.ibs1_count = res1_q;
  assign out_o.ibs2_count = res2_q;

  // After a result is captured the totals start over from zero.
  `GIC_ASSERT_NEXT(a_back_clear,
    emit,
    tot0_q == '0 && tot1_q == '0 && tot2_q == '0,
    "back: totals not cleared after a last beat")

  // A result only appears after a last beat was taken.
  `GIC_ASSERT_ALWAYS(a_back_rise,
    !$rose(out_valid_q) || $past(emit),
    "back: result valid without a last beat")

endmodule

>>> src/genotype_ibs_counter.sv
// The block takes one genotype word pair per cycle and keeps that rate
// indefinitely while the result side keeps up. A result beat passes in turn
// through the classification register and the two-entry queue to the result
// register, which loads when the accumulator takes the last beat. The result
// register lets input continue while a finished result waits to be taken.
// ----------------------------------------------------------------------------
// Genotype IBS counter top level
// Counts IBS0, IBS1 and IBS2 genotype positions per sample pair with
// saturating totals and emits them on the last word of each pair.
// ----------------------------------------------------------------------------
module genotype_ibs_counter
  import gic_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  gic_in_if.sink    in_i,
  gic_out_if.source out_o
);

  cls_t front_cls, head_cls;
  logic front_valid, front_ready;
  logic head_valid, head_ready;

  gic_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cls_o       (front_cls),
    .cls_valid_o (front_valid),
    .cls_ready_i (front_ready)
  );

  gic_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cls),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (head_cls),
    .pop_valid_o  (head_valid),
    .pop_ready_i  (head_ready)
  );

  gic_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head_cls),
    .head_valid_i (head_valid),
    .head_ready_o (head_ready),
    .out_o        (out_o)
  );

endmodule
